// ===== hdl/pfa_pkg.sv =====
// Shared codes and controller/datapath signal groups for the frame allocator.
package pfa_pkg;

	localparam int ACT_W = 2;
	localparam int FRAME_W = 8;
	localparam int PC_W = 7;
	localparam int FC_W = 9;
	localparam int ST_W = 2;

	localparam logic [ACT_W-1:0] ACT_FORMAT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_GET = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PUT = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RUN = 2'd3;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL = 2'd3;

	localparam logic [1:0] LIM_MAX = 2'd0;
	localparam logic [1:0] LIM_N = 2'd1;
	localparam logic [1:0] LIM_CNT = 2'd2;

	localparam logic [1:0] RS_ZERO = 2'd0;
	localparam logic [1:0] RS_HEAD = 2'd1;
	localparam logic [1:0] RS_RUN = 2'd2;

	typedef struct packed {
		logic            load;
		logic            clr_idx;
		logic            fill;
		logic            fmt_set;
		logic            pop;
		logic            pop_done;
		logic            push;
		logic            mark_rd;
		logic            scan_rd;
		logic            comp_rd;
		logic            comp_fin;
		logic            res;
		logic [ST_W-1:0] res_st;
		logic [1:0]      res_sel;
		logic [1:0]      lim;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             n_zero;
		logic             cnt_zero;
		logic             cnt_full;
		logic             fin_bad;
		logic             req_bad;
		logic             walk_last;
		logic             found;
		logic             out_free;
		logic             emit_last;
	} sts_t;

endpackage

// ===== hdl/pfa_if.sv =====
// Channel interfaces: request beats, result beats and the frame_count write.
interface pfa_item_if;
	logic                         valid;
	logic                         ready;
	logic [pfa_pkg::ACT_W-1:0]    action;
	logic [pfa_pkg::FRAME_W-1:0]  frame_in;
	logic [pfa_pkg::PC_W-1:0]     page_count;
	modport source (output valid, action, frame_in, page_count, input ready);
	modport sink (input valid, action, frame_in, page_count, output ready);
	modport monitor (input valid, ready, action, frame_in, page_count);
endinterface

interface pfa_res_if;
	logic                         valid;
	logic                         ready;
	logic [pfa_pkg::ST_W-1:0]     status;
	logic [pfa_pkg::FRAME_W-1:0]  frame_out;
	logic                         last;
	modport source (output valid, status, frame_out, last, input ready);
	modport sink (input valid, status, frame_out, last, output ready);
	modport monitor (input valid, ready, status, frame_out, last);
endinterface

interface pfa_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [pfa_pkg::FC_W-1:0]     data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
	modport monitor (input valid, ready, data);
endinterface

// ===== hdl/pfa_ctrl.sv =====
// Sequencer for the frame allocator: walks, drains and result issue.
module pfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pfa_pkg::sts_t     sts,
	output pfa_pkg::cmd_t     cmd
);

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DISP  = 4'd2;
	localparam logic [3:0] S_FILL  = 4'd3;
	localparam logic [3:0] S_GETW  = 4'd4;
	localparam logic [3:0] S_MARK  = 4'd5;
	localparam logic [3:0] S_MARKD = 4'd6;
	localparam logic [3:0] S_SCAN  = 4'd7;
	localparam logic [3:0] S_SCAND = 4'd8;
	localparam logic [3:0] S_SCANE = 4'd9;
	localparam logic [3:0] S_COMP  = 4'd10;
	localparam logic [3:0] S_COMPD = 4'd11;
	localparam logic [3:0] S_COMPF = 4'd12;
	localparam logic [3:0] S_EMIT  = 4'd13;
	localparam logic [3:0] S_RESP  = 4'd14;

	logic [3:0]                state_q, state_d;
	logic [pfa_pkg::ST_W-1:0]  rst_q, rst_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		rst_d = rst_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cmd.fill = 1'b1;
				cmd.lim = pfa_pkg::LIM_MAX;
				if (sts.walk_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_RESP;
				unique case (sts.act)
					pfa_pkg::ACT_FORMAT: begin
						if (sts.n_zero) rst_d = pfa_pkg::ST_BAD;
						else begin
							cmd.fmt_set = 1'b1;
							state_d = S_FILL;
						end
					end
					pfa_pkg::ACT_GET: begin
						if (sts.cnt_zero) rst_d = pfa_pkg::ST_EMPTY;
						else begin
							cmd.pop = 1'b1;
							state_d = S_GETW;
						end
					end
					pfa_pkg::ACT_PUT: begin
						if (sts.fin_bad) rst_d = pfa_pkg::ST_BAD;
						else if (sts.cnt_full) rst_d = pfa_pkg::ST_FULL;
						else begin
							cmd.push = 1'b1;
							rst_d = pfa_pkg::ST_OK;
						end
					end
					default: begin
						if (sts.req_bad || sts.n_zero) rst_d = pfa_pkg::ST_BAD;
						else if (sts.cnt_zero) state_d = S_MARKD;
						else state_d = S_MARK;
					end
				endcase
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				cmd.lim = pfa_pkg::LIM_N;
				if (sts.walk_last) begin
					rst_d = pfa_pkg::ST_OK;
					state_d = S_RESP;
				end
			end
			S_GETW: begin
				if (sts.out_free) begin
					cmd.res = 1'b1;
					cmd.res_st = pfa_pkg::ST_OK;
					cmd.res_sel = pfa_pkg::RS_HEAD;
					cmd.pop_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_MARK: begin
				cmd.mark_rd = 1'b1;
				cmd.lim = pfa_pkg::LIM_CNT;
				if (sts.walk_last) state_d = S_MARKD;
			end
			S_MARKD: begin
				cmd.clr_idx = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.lim = pfa_pkg::LIM_N;
				if (sts.walk_last) state_d = S_SCAND;
			end
			S_SCAND: begin
				cmd.clr_idx = 1'b1;
				state_d = S_SCANE;
			end
			S_SCANE: begin
				if (sts.found) state_d = S_COMP;
				else begin
					rst_d = pfa_pkg::ST_EMPTY;
					state_d = S_RESP;
				end
			end
			S_COMP: begin
				cmd.comp_rd = 1'b1;
				cmd.lim = pfa_pkg::LIM_CNT;
				if (sts.walk_last) state_d = S_COMPD;
			end
			S_COMPD: state_d = S_COMPF;
			S_COMPF: begin
				cmd.comp_fin = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.res = 1'b1;
					cmd.res_st = pfa_pkg::ST_OK;
					cmd.res_sel = pfa_pkg::RS_RUN;
					if (sts.emit_last) state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.res = 1'b1;
					cmd.res_st = rst_q;
					cmd.res_sel = pfa_pkg::RS_ZERO;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			rst_q <= pfa_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			rst_q <= rst_d;
		end
	end

endmodule

// ===== hdl/pfa_dp.sv =====
// Datapath: ring-ordered free list, free bitmap, walk counters, run search, result register.
module pfa_dp #(
	parameter int MAX_FRAMES = 256,
	parameter int MAX_RUN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pfa_pkg::ACT_W-1:0]     action,
	input  logic [pfa_pkg::FRAME_W-1:0]   frame_in,
	input  logic [pfa_pkg::PC_W-1:0]      page_count,
	pfa_cfg_if.sink                       cfg,
	pfa_res_if.source                     res,
	input  pfa_pkg::cmd_t                 cmd,
	output pfa_pkg::sts_t                 sts
);

	localparam int FW = $clog2(MAX_FRAMES);
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int XW = CW + 10;
	localparam int RST_CNT = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

	logic [pfa_pkg::FC_W-1:0]   fc_q;
	logic [CW-1:0]              n;
	logic [pfa_pkg::ACT_W-1:0]  act_q;
	logic [pfa_pkg::FRAME_W-1:0] fin_q;
	logic [pfa_pkg::PC_W-1:0]   req_q;
	logic [FW-1:0]              head_q, head_dec, head_inc;
	logic [CW-1:0]              cnt_q, idx_q, w_q, idx_s1, lim;
	logic [pfa_pkg::PC_W-1:0]   run_q, k_q;
	logic [FW-1:0]              start_q;
	logic                       found_q, mark_s1, scan_s1, comp_s1, keep, emit_last, out_free;
	logic                       ov_q;

	logic [FW-1:0] lst [MAX_FRAMES];
	logic [FW-1:0] lst_rd_q, lst_wa, lst_wd, lst_ra;
	logic          lst_we, lst_re;
	logic          bm [MAX_FRAMES];
	logic          bm_rd_q, bm_we, bm_wd;
	logic [FW-1:0] bm_wa;

	function automatic logic [FW-1:0] phys(input logic [FW-1:0] h, input logic [CW-1:0] off);
		logic [XW-1:0] s;
		s = XW'(h) + XW'(off);
		if (s >= XW'(MAX_FRAMES)) s = s - XW'(MAX_FRAMES);
		return s[FW-1:0];
	endfunction

	assign n = (XW'(fc_q) > XW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(fc_q);
	assign head_dec = (head_q == '0) ? FW'(MAX_FRAMES - 1) : head_q - 1'b1;
	assign head_inc = (XW'(head_q) == XW'(MAX_FRAMES - 1)) ? '0 : head_q + 1'b1;
	assign cfg.ready = 1'b1;

	always_comb begin
		case (cmd.lim)
			pfa_pkg::LIM_MAX: lim = CW'(MAX_FRAMES);
			pfa_pkg::LIM_N:   lim = n;
			default:          lim = cnt_q;
		endcase
	end

	assign keep = !(XW'(lst_rd_q) >= XW'(start_q)
		&& XW'(lst_rd_q) < XW'(start_q) + XW'(req_q));
	assign emit_last = (XW'(k_q) + 1 == XW'(req_q));
	assign out_free = !ov_q || res.ready;

	always_comb begin
		sts.act = act_q;
		sts.n_zero = (n == '0);
		sts.cnt_zero = (cnt_q == '0);
		sts.cnt_full = (XW'(cnt_q) >= XW'(MAX_FRAMES));
		sts.fin_bad = (XW'(fin_q) >= XW'(n));
		sts.req_bad = (req_q == '0) || (XW'(req_q) > XW'(MAX_RUN));
		sts.walk_last = (XW'(idx_q) + 1 == XW'(lim));
		sts.found = found_q;
		sts.out_free = out_free;
		sts.emit_last = emit_last;
	end

	always_comb begin
		lst_re = cmd.pop || cmd.mark_rd || cmd.comp_rd;
		lst_ra = cmd.pop ? head_q : phys(head_q, idx_q);
		lst_we = 1'b0;
		lst_wa = idx_q[FW-1:0];
		lst_wd = idx_q[FW-1:0];
		if (cmd.fill) begin
			lst_we = 1'b1;
		end else if (cmd.push) begin
			lst_we = 1'b1;
			lst_wa = head_dec;
			lst_wd = FW'(fin_q);
		end else if (comp_s1 && keep) begin
			lst_we = 1'b1;
			lst_wa = phys(head_q, w_q);
			lst_wd = lst_rd_q;
		end
		bm_we = 1'b0;
		bm_wa = idx_q[FW-1:0];
		bm_wd = 1'b0;
		if (cmd.fill || cmd.scan_rd) begin
			bm_we = 1'b1;
		end else if (mark_s1 && XW'(lst_rd_q) < XW'(n)) begin
			bm_we = 1'b1;
			bm_wa = lst_rd_q;
			bm_wd = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (lst_we) lst[lst_wa] <= lst_wd;
		if (lst_re) lst_rd_q <= lst[lst_ra];
	end

	always_ff @(posedge clk) begin
		if (bm_we) bm[bm_wa] <= bm_wd;
		if (cmd.scan_rd) bm_rd_q <= bm[idx_q[FW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			fin_q <= frame_in;
			req_q <= page_count;
		end
		if (cmd.res) begin
			res.status <= cmd.res_st;
			case (cmd.res_sel)
				pfa_pkg::RS_HEAD: res.frame_out <= 8'(lst_rd_q);
				pfa_pkg::RS_RUN:  res.frame_out <= 8'(XW'(start_q) + XW'(k_q));
				default:          res.frame_out <= '0;
			endcase
			res.last <= (cmd.res_sel == pfa_pkg::RS_RUN) ? emit_last : 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= 9'd256;
			head_q <= '0;
			cnt_q <= CW'(RST_CNT);
			idx_q <= '0;
			w_q <= '0;
			idx_s1 <= '0;
			run_q <= '0;
			k_q <= '0;
			start_q <= '0;
			found_q <= 1'b0;
			mark_s1 <= 1'b0;
			scan_s1 <= 1'b0;
			comp_s1 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cfg.valid) fc_q <= cfg.data;
			if (cmd.load) begin
				idx_q <= '0;
				w_q <= '0;
				run_q <= '0;
				found_q <= 1'b0;
				k_q <= '0;
			end else if (cmd.clr_idx) begin
				idx_q <= '0;
				w_q <= '0;
			end else begin
				if (cmd.fill || cmd.mark_rd || cmd.scan_rd || cmd.comp_rd) idx_q <= idx_q + 1'b1;
				if (comp_s1 && keep) w_q <= w_q + 1'b1;
			end
			if (cmd.fmt_set) begin
				head_q <= '0;
				cnt_q <= n;
			end else if (cmd.pop_done) begin
				head_q <= head_inc;
				cnt_q <= cnt_q - 1'b1;
			end else if (cmd.push) begin
				head_q <= head_dec;
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.comp_fin) begin
				cnt_q <= w_q;
			end
			mark_s1 <= cmd.mark_rd;
			scan_s1 <= cmd.scan_rd;
			comp_s1 <= cmd.comp_rd;
			idx_s1 <= idx_q;
			if (scan_s1 && !found_q) begin
				if (bm_rd_q) begin
					if (run_q == '0) start_q <= idx_s1[FW-1:0];
					run_q <= run_q + 1'b1;
					if (run_q + 1'b1 == req_q) found_q <= 1'b1;
				end else begin
					run_q <= '0;
				end
			end
			if (cmd.res && cmd.res_sel == pfa_pkg::RS_RUN) k_q <= k_q + 1'b1;
			if (cmd.res) ov_q <= 1'b1;
			else if (res.ready) ov_q <= 1'b0;
		end
	end

	assign res.valid = ov_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(cnt_q) <= XW'(MAX_FRAMES))
		else $error("free count above capacity");
	a_found_run: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> run_q == req_q)
		else $error("run found with wrong length");
	a_w_le_idx: assert property (@(posedge clk) disable iff (!arst_n)
		w_q <= idx_q)
		else $error("compaction write ahead of read");
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res |-> out_free)
		else $error("result loaded over a held beat");

endmodule

// ===== hdl/physical_frame_allocator.sv =====
// Top level of the physical frame allocator.
// Requests arrive on op (action, frame_in, page_count); each yields one result
// beat on res (status, frame_out, last), except a granted run, which yields
// page_count beats in ascending frame order with last on the final one.
// frame_count is written on cfg, which is always ready; write it only when idle.
// Requests are handled one at a time; op.ready is high only while idle.
// A get-contiguous request walks the free list into the bitmap, scans the bitmap
// for a run, compacts the list and then emits one beat per granted frame; the
// walks are bounded by the list and bitmap memories, one entry per cycle.
// After reset the list is rebuilt as frames 0 upward and the bitmap cleared,
// a pass during which op.ready stays low.
// A stalled res holds its beat in the output register; the sequencer waits.
module physical_frame_allocator #(
	parameter int MAX_FRAMES = 256,
	parameter int MAX_RUN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	pfa_item_if.sink   op,
	pfa_res_if.source  res,
	pfa_cfg_if.sink    cfg
);

	pfa_pkg::cmd_t cmd;
	pfa_pkg::sts_t sts;
	logic          in_ready;

	assign op.ready = in_ready;

	pfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (op.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfa_dp #(
		.MAX_FRAMES (MAX_FRAMES),
		.MAX_RUN    (MAX_RUN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.action     (op.action),
		.frame_in   (op.frame_in),
		.page_count (op.page_count),
		.cfg        (cfg),
		.res        (res),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

// ===== dv/pfa_checker.sv =====
// Checker for the frame allocator: watches the channels, predicts results and compares them.
module pfa_checker (
	input  logic          clk,
	input  logic          arst_n,
	pfa_item_if.monitor   op_mon,
	pfa_res_if.monitor    res_mon,
	pfa_cfg_if.monitor    cfg_mon,
	output int            fail_count,
	output int            pending
);

	typedef struct packed {
		logic [pfa_pkg::ST_W-1:0]    status;
		logic [pfa_pkg::FRAME_W-1:0] frame;
		logic                        last;
	} grant_t;

	logic [pfa_pkg::FRAME_W-1:0] list_q [256];
	int                          list_len;
	logic [pfa_pkg::FC_W-1:0]    frames_reg;
	grant_t                      grant_q [$];

	task automatic report(input string what, input grant_t got, input grant_t want);
		$display("mismatch %s: got st=%0d fr=%0d last=%0d, want st=%0d fr=%0d last=%0d",
			what, got.status, got.frame, got.last, want.status, want.frame, want.last);
		fail_count++;
	endtask

	function automatic grant_t mk(input logic [pfa_pkg::ST_W-1:0] s, input int f,
			input logic l);
		grant_t g;
		g.status = s;
		g.frame = f[pfa_pkg::FRAME_W-1:0];
		g.last = l;
		return g;
	endfunction

	task automatic allocate(input logic [pfa_pkg::ACT_W-1:0] act,
			input logic [pfa_pkg::FRAME_W-1:0] fin, input logic [pfa_pkg::PC_W-1:0] req);
		int n;
		bit avail [256];
		int start, run, w;
		bit found;
		n = (frames_reg > 9'd256) ? 256 : int'(frames_reg);
		start = 0;
		run = 0;
		w = 0;
		found = 0;
		case (act)
			pfa_pkg::ACT_FORMAT: begin
				if (n == 0) grant_q.push_back(mk(pfa_pkg::ST_BAD, 0, 1'b1));
				else begin
					for (int i = 0; i < n; i++) list_q[i] = i[pfa_pkg::FRAME_W-1:0];
					list_len = n;
					grant_q.push_back(mk(pfa_pkg::ST_OK, 0, 1'b1));
				end
			end
			pfa_pkg::ACT_GET: begin
				if (list_len == 0) grant_q.push_back(mk(pfa_pkg::ST_EMPTY, 0, 1'b1));
				else begin
					grant_q.push_back(mk(pfa_pkg::ST_OK, int'(list_q[0]), 1'b1));
					for (int i = 1; i < list_len; i++) list_q[i-1] = list_q[i];
					list_len--;
				end
			end
			pfa_pkg::ACT_PUT: begin
				if (fin >= n) grant_q.push_back(mk(pfa_pkg::ST_BAD, 0, 1'b1));
				else if (list_len >= 256) grant_q.push_back(mk(pfa_pkg::ST_FULL, 0, 1'b1));
				else begin
					for (int i = list_len; i > 0; i--) list_q[i] = list_q[i-1];
					list_q[0] = fin;
					list_len++;
					grant_q.push_back(mk(pfa_pkg::ST_OK, 0, 1'b1));
				end
			end
			default: begin
				if (req == 0 || req > 64 || n == 0)
					grant_q.push_back(mk(pfa_pkg::ST_BAD, 0, 1'b1));
				else begin
					for (int i = 0; i < 256; i++) avail[i] = 0;
					for (int i = 0; i < list_len; i++)
						if (list_q[i] < n) avail[list_q[i]] = 1;
					for (int i = 0; i < n && !found; i++) begin
						if (avail[i]) begin
							if (run == 0) start = i;
							run++;
							if (run == req) found = 1;
						end else run = 0;
					end
					if (!found) grant_q.push_back(mk(pfa_pkg::ST_EMPTY, 0, 1'b1));
					else begin
						for (int i = 0; i < list_len; i++)
							if (!(list_q[i] >= start && list_q[i] < start + req))
								list_q[w++] = list_q[i];
						list_len = w;
						for (int i = 0; i < req; i++)
							grant_q.push_back(mk(pfa_pkg::ST_OK, start + i, (i + 1 == req)));
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) list_q[i] = i[pfa_pkg::FRAME_W-1:0];
			list_len = 256;
			frames_reg = 9'd256;
			grant_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				got = {res_mon.status, res_mon.frame_out, res_mon.last};
				if (grant_q.size() == 0) report("unexpected beat", got, got);
				else begin
					want = grant_q.pop_front();
					if (got.status !== want.status) report("status", got, want);
					else if (got.frame !== want.frame) report("frame_out", got, want);
					else if (got.last !== want.last) report("last", got, want);
				end
			end
			if (cfg_mon.valid && cfg_mon.ready) frames_reg = cfg_mon.data;
			if (op_mon.valid && op_mon.ready)
				allocate(op_mon.action, op_mon.frame_in, op_mon.page_count);
			pending = grant_q.size();
		end
	end
endmodule

// ===== dv/physical_frame_allocator_tb.sv =====
// Testbench top for the frame allocator: stimulus, idling phases and verdict.
module physical_frame_allocator_tb;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   send_idle;
	int   recv_stall;
	int   hold_cycles;
	int   quiet;
	int   ph_idle [4];
	int   ph_stall [4];
	int   fc [4];

	pfa_item_if op ();
	pfa_res_if  res ();
	pfa_cfg_if  cfg ();

	physical_frame_allocator i_dut (.clk(clk), .arst_n(arst_n), .op(op), .res(res), .cfg(cfg));
	pfa_checker i_chk (.clk(clk), .arst_n(arst_n), .op_mon(op), .res_mon(res), .cfg_mon(cfg),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		op.valid = 0;
		op.action = pfa_pkg::ACT_FORMAT;
		op.frame_in = 0;
		op.page_count = 0;
		cfg.valid = 0;
		cfg.data = 0;
		res.ready = 0;
		send_idle = 0;
		recv_stall = 0;
		hold_cycles = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			res.ready <= 0;
		end else res.ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (!arst_n) quiet <= 0;
		else if ((op.valid && op.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			quiet <= 0;
		else quiet <= quiet + 1;
	end

	always @(posedge clk) begin
		if (quiet > 20000) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send(input logic [pfa_pkg::ACT_W-1:0] a, input int f, input int p);
		while ($urandom_range(99) < send_idle) begin
			op.valid <= 0;
			@(posedge clk);
		end
		op.valid <= 1;
		op.action <= a;
		op.frame_in <= f[pfa_pkg::FRAME_W-1:0];
		op.page_count <= p[pfa_pkg::PC_W-1:0];
		@(posedge clk);
		while (!op.ready) @(posedge clk);
	endtask

	task automatic drain();
		op.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic set_frames(input int v);
		drain();
		cfg.valid <= 1;
		cfg.data <= v[pfa_pkg::FC_W-1:0];
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 0;
	endtask

	task automatic rand_item();
		int r;
		r = $urandom_range(99);
		if (r < 10) send(pfa_pkg::ACT_FORMAT, $urandom, 0);
		else if (r < 35) send(pfa_pkg::ACT_GET, 0, $urandom);
		else if (r < 65) send(pfa_pkg::ACT_PUT,
			($urandom_range(3) == 0) ? $urandom : $urandom_range(40), $urandom);
		else if (r < 95) send(pfa_pkg::ACT_RUN, $urandom,
			($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 6));
		else send(pfa_pkg::ACT_RUN, 0, $urandom_range(1) ? 0 : $urandom_range(65, 127));
	endtask

	initial begin
		ph_idle = '{0, 48, 0, 17};
		ph_stall = '{0, 0, 48, 17};
		fc = '{40, 1, 256, 300};
		@(posedge arst_n);
		// directed
		send(pfa_pkg::ACT_PUT, 5, 0);
		send(pfa_pkg::ACT_PUT, 255, 0);
		send(pfa_pkg::ACT_GET, 0, 0);
		send(pfa_pkg::ACT_RUN, 0, 64);
		send(pfa_pkg::ACT_RUN, 0, 0);
		send(pfa_pkg::ACT_RUN, 0, 65);
		send(pfa_pkg::ACT_RUN, 0, 127);
		set_frames(0);
		send(pfa_pkg::ACT_FORMAT, 0, 0);
		send(pfa_pkg::ACT_RUN, 0, 1);
		send(pfa_pkg::ACT_PUT, 0, 0);
		send(pfa_pkg::ACT_GET, 0, 0);
		set_frames(8);
		send(pfa_pkg::ACT_FORMAT, 0, 0);
		send(pfa_pkg::ACT_PUT, 3, 0);
		send(pfa_pkg::ACT_PUT, 8, 0);
		send(pfa_pkg::ACT_RUN, 0, 4);
		send(pfa_pkg::ACT_RUN, 0, 8);
		for (int i = 0; i < 5; i++) send(pfa_pkg::ACT_GET, 0, 0);
		set_frames(511);
		send(pfa_pkg::ACT_FORMAT, 0, 0);
		send(pfa_pkg::ACT_RUN, 0, 3);
		// random phases
		for (int ph = 0; ph < 4; ph++) begin
			set_frames(fc[ph]);
			send_idle = ph_idle[ph];
			recv_stall = ph_stall[ph];
			send(pfa_pkg::ACT_FORMAT, 0, 0);
			if (ph == 2) begin
				hold_cycles = 3000;
				for (int i = 0; i < 6; i++) send(pfa_pkg::ACT_RUN, 0, $urandom_range(1, 8));
			end
			for (int i = 0; i < 33; i++) rand_item();
			if (ph == 1) begin
				drain();
				for (int i = 0; i < 4; i++) send(pfa_pkg::ACT_GET, 0, 0);
			end
		end
		drain();
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
